/* hw/rtl/track_longitude_window_splitter_core_defines.svh */
// Assertion macros for the longitude window track splitter.
// Included by the top level only; needs no other file.
`ifndef TRACK_LONGITUDE_WINDOW_SPLITTER_CORE_DEFINES_SVH
`define TRACK_LONGITUDE_WINDOW_SPLITTER_CORE_DEFINES_SVH

// Property that holds whenever reset is not asserted.
`define TLWS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked on the next clock edge.
`define TLWS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/tlws_pkg.sv */
// Shared types and constants of the longitude window track splitter.
// No dependencies.
package tlws_pkg;
	localparam int FRAC_BITS_DEF = 23;
	localparam int LON_W = 32;
	localparam int LAT_W = 31;
	localparam int ALT_W = 32;
	localparam int WIDE_W = 40;

	typedef enum logic [1:0] {
		KIND_ORIG  = 2'd0,
		KIND_ENTRY = 2'd1,
		KIND_EXIT  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_LEFT  = 2'd0,
		REG_RIGHT = 2'd1,
		REG_FULL  = 2'd2
	} reg_idx_t;

	// One unit of work: emit an original point or compute an edge point.
	typedef struct packed {
		logic                    is_edge;
		logic                    leaving;
		logic                    seg;
		logic                    last;
		logic signed [LON_W-1:0] cur_lon;
		logic signed [LAT_W-1:0] cur_lat;
		logic signed [ALT_W-1:0] cur_alt;
		logic signed [LON_W-1:0] p_lon;
		logic signed [LAT_W-1:0] p_lat;
		logic signed [ALT_W-1:0] p_alt;
		logic signed [LON_W-1:0] left;
		logic signed [LON_W-1:0] right;
	} job_t;
endpackage

/* hw/rtl/track_longitude_window_splitter_core.sv */
// Longitude window track splitter.
// Input channel (in_valid/in_stall) takes one track point per request. The
// front end classifies it against the window held in the configuration
// registers and queues up to three jobs; the back end turns each job into one
// result on the output channel (out_valid/out_stall), last marking the final
// result of a point. An edge result passes through the geometry and multiply
// states and, unless trivial, the 80-step restoring divider and a finish state;
// an original point goes straight to the output state. The back end takes no
// new job until its result is registered. The input stalls while a point's
// jobs are queued, so a following point waits at the input until the queue
// has room.
// A stalled output holds its result; the back end then stops and the job
// queue fills, which in turn stalls the input.
// Reset returns the window to -180..+180 degrees, not full width, and the
// track state to a visible previous point at the origin.
// Configuration writes (cfg_valid/cfg_ready) are always taken.
// Depends on tlws_pkg, the defines header, tlws_front, tlws_queue and tlws_back.
`include "track_longitude_window_splitter_core_defines.svh"
module track_longitude_window_splitter_core #(
	parameter int FRAC_BITS = tlws_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [1:0]                        cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [tlws_pkg::LON_W-1:0] point_lon,
	input  logic signed [tlws_pkg::LAT_W-1:0] point_lat,
	input  logic signed [tlws_pkg::ALT_W-1:0] point_alt,
	input  logic                              first_point,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              segment,
	output logic signed [tlws_pkg::LON_W-1:0] out_lon,
	output logic signed [tlws_pkg::LAT_W-1:0] out_lat,
	output logic signed [tlws_pkg::ALT_W-1:0] out_alt,
	output logic [1:0]                        kind,
	output logic                              last
);
	localparam logic signed [tlws_pkg::LON_W-1:0] D180 =
		tlws_pkg::LON_W'(180) <<< FRAC_BITS;

	logic signed [tlws_pkg::LON_W-1:0] left_q, right_q;
	logic full_q;
	logic fj_valid, q_full, q_valid, q_take;
	tlws_pkg::job_t fj, qj;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= -D180; right_q <= D180; full_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				tlws_pkg::REG_LEFT:  left_q <= cfg_data;
				tlws_pkg::REG_RIGHT: right_q <= cfg_data;
				tlws_pkg::REG_FULL:  full_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tlws_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .point_lon, .point_lat, .point_alt,
		.first_point, .left_q_i(left_q), .right_q_i(right_q), .full_q_i(full_q),
		.job_valid(fj_valid), .job(fj), .job_full(q_full)
	);

	tlws_queue u_queue (
		.clk, .arst_n, .wr_valid(fj_valid), .wr_job(fj), .full(q_full),
		.rd_valid(q_valid), .rd_job(qj), .rd_take(q_take)
	);

	tlws_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .job_valid(q_valid), .job(qj), .job_take(q_take),
		.out_valid, .out_stall, .segment, .out_lon, .out_lat, .out_alt, .kind, .last
	);

	`TLWS_ASSERT(a_kind_legal, !out_valid || kind != 2'd3, "illegal result kind")
	`TLWS_ASSERT(a_exit_seg0, !out_valid || kind != tlws_pkg::KIND_EXIT || !segment,
		"exit edge outside segment 0")
	`TLWS_ASSERT_NEXT(a_no_write_full, q_full, !(q_full && fj_valid), "job issued to full queue")
endmodule

/* hw/rtl/tlws_front.sv */
// Front end: visibility, crossing test and track state; emits jobs.
// Depends on tlws_pkg.
module tlws_front #(
	parameter int FRAC_BITS = tlws_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [tlws_pkg::LON_W-1:0] point_lon,
	input  logic signed [tlws_pkg::LAT_W-1:0] point_lat,
	input  logic signed [tlws_pkg::ALT_W-1:0] point_alt,
	input  logic                              first_point,
	input  logic signed [tlws_pkg::LON_W-1:0] left_q_i,
	input  logic signed [tlws_pkg::LON_W-1:0] right_q_i,
	input  logic                              full_q_i,
	output logic                              job_valid,
	output tlws_pkg::job_t                    job,
	input  logic                              job_full
);
	localparam int W = tlws_pkg::WIDE_W;
	localparam logic signed [W-1:0] D90 = W'(90) <<< FRAC_BITS;

	typedef enum logic [1:0] {F_IDLE, F_J1, F_J2} fstate_t;
	fstate_t st_q;

	logic signed [tlws_pkg::LON_W-1:0] prev_lon_q;
	logic signed [tlws_pkg::LAT_W-1:0] prev_lat_q;
	logic signed [tlws_pkg::ALT_W-1:0] prev_alt_q;
	logic prev_vis_q, seg_q, nonempty_q, finished_q;
	tlws_pkg::job_t j1_q, j2_q;
	logic [1:0] njobs_q;

	logic signed [W-1:0] lon, pl, L, R, lat_w;
	logic signed [tlws_pkg::LAT_W-1:0] lat;
	logic signed [tlws_pkg::LON_W-1:0] pl_eff;
	logic on, crossed, anti, fin_eff, nonempty_eff, seg_eff, pvis_eff;

	function automatic logic we(input logic signed [W-1:0] a, input logic signed [W-1:0] b);
		we = (a > D90) && (b < -D90);
	endfunction

	always_comb begin
		lon = W'(point_lon);
		lat_w = W'(point_lat);
		if (lat_w > D90) lat = tlws_pkg::LAT_W'(D90);
		else if (lat_w < -D90) lat = tlws_pkg::LAT_W'(-D90);
		else lat = point_lat;
		pl_eff = first_point ? point_lon : prev_lon_q;
		pl = W'(pl_eff);
		L = W'(left_q_i);
		R = W'(right_q_i);
		fin_eff = first_point ? 1'b0 : finished_q;
		nonempty_eff = first_point ? 1'b0 : nonempty_q;
		seg_eff = first_point ? 1'b0 : seg_q;
		pvis_eff = first_point ? 1'b1 : prev_vis_q;
		if (full_q_i) on = 1'b1;
		else if (L <= R) on = (lon > L) && (lon <= R);
		else on = (lon > L) || (lon <= R);
		anti = we(pl, lon) || we(lon, pl);
		if (!anti)
			crossed = (pl <= R && lon > R) || (pl >= R && lon < R) ||
				(pl >= L && lon < L) || (pl <= L && lon > L);
		else
			crossed = (pl > R && we(pl, R) && lon > R) || (pl <= R && lon <= R && we(R, lon)) ||
				(pl < R && we(pl, R) && lon < R) || (pl >= R && lon >= R && we(R, lon)) ||
				(pl < L && we(L, pl) && lon < L) || (pl >= L && lon >= L && we(lon, L)) ||
				(pl > L && we(L, pl) && lon > L) || (pl <= L && lon <= L && we(lon, L));
	end

	assign in_stall = (st_q != F_IDLE);

	always_comb begin
		job_valid = 1'b0;
		job = j1_q;
		case (st_q)
			F_J1: begin
				job_valid = !job_full;
				job = j1_q;
			end
			F_J2: begin
				job_valid = !job_full;
				job = j2_q;
			end
			default: job_valid = 1'b0;
		endcase
	end

	// base job fields shared by every job of one point
	function automatic tlws_pkg::job_t mk(input logic e, input logic lv, input logic s,
		input logic lst, input logic signed [tlws_pkg::LAT_W-1:0] la,
		input logic signed [tlws_pkg::LON_W-1:0] plon);
		tlws_pkg::job_t r;
		r.is_edge = e; r.leaving = lv; r.seg = s; r.last = lst;
		r.cur_lon = point_lon; r.cur_lat = la; r.cur_alt = point_alt;
		r.p_lon = plon; r.p_lat = prev_lat_q; r.p_alt = prev_alt_q;
		r.left = left_q_i; r.right = right_q_i;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
			prev_lon_q <= '0; prev_lat_q <= '0; prev_alt_q <= '0;
			prev_vis_q <= 1'b1; seg_q <= 1'b0; nonempty_q <= 1'b0; finished_q <= 1'b0;
			njobs_q <= '0;
		end else begin
			case (st_q)
				F_IDLE: begin
					if (in_valid) begin
						prev_lon_q <= pl_eff; seg_q <= seg_eff;
						nonempty_q <= nonempty_eff; finished_q <= fin_eff;
						prev_vis_q <= pvis_eff;
						if (!fin_eff) begin
							if ((on && !crossed) || (on && !pvis_eff)) begin
								if (!first_point && !nonempty_eff) begin
									j1_q <= mk(1'b1, 1'b0, seg_eff, 1'b0, lat, pl_eff);
									j2_q <= mk(1'b0, 1'b0, seg_eff, 1'b1, lat, pl_eff);
									njobs_q <= 2'd1;
								end else begin
									j1_q <= mk(1'b0, 1'b0, seg_eff, 1'b1, lat, pl_eff);
									njobs_q <= 2'd0;
								end
								st_q <= F_J1;
								nonempty_q <= 1'b1;
							end else if (nonempty_eff) begin
								if (seg_eff) begin
									finished_q <= 1'b1;
								end else begin
									j1_q <= mk(1'b1, 1'b1, 1'b0, !on, lat, pl_eff);
									seg_q <= 1'b1;
									nonempty_q <= on;
									st_q <= F_J1;
									njobs_q <= on ? 2'd2 : 2'd0;
									j2_q <= mk(1'b1, 1'b0, 1'b1, 1'b0, lat, pl_eff);
								end
							end
							if (!(nonempty_eff && seg_eff &&
								!((on && !crossed) || (on && !pvis_eff)))) begin
								prev_lon_q <= point_lon; prev_lat_q <= lat;
								prev_alt_q <= point_alt; prev_vis_q <= on;
							end
						end
					end
				end
				F_J1: if (!job_full) begin
					if (njobs_q == 2'd0) st_q <= F_IDLE;
					else st_q <= F_J2;
				end
				F_J2: if (!job_full) begin
					if (njobs_q == 2'd2) begin
						// entry job issued; queue the original point of segment 1
						j2_q.is_edge <= 1'b0;
						j2_q.last <= 1'b1;
						njobs_q <= 2'd0;
					end else st_q <= F_IDLE;
				end
				default: st_q <= F_IDLE;
			endcase
		end
	end
endmodule

/* hw/rtl/tlws_queue.sv */
// Two-entry job queue between front and back ends.
// Depends on tlws_pkg.
module tlws_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	input  tlws_pkg::job_t wr_job,
	output logic           full,
	output logic           rd_valid,
	output tlws_pkg::job_t rd_job,
	input  logic           rd_take
);
	tlws_pkg::job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && !full) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr_valid && !full) wp_q <= !wp_q;
			if (rd_take && rd_valid) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'((wr_valid && !full) ? 1 : 0) - 2'((rd_take && rd_valid) ? 1 : 0);
		end
	end
endmodule

/* hw/rtl/tlws_back.sv */
// Back end: edge geometry, iterative rounded division, output register.
// Depends on tlws_pkg.
module tlws_back #(
	parameter int FRAC_BITS = tlws_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              job_valid,
	input  tlws_pkg::job_t                    job,
	output logic                              job_take,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              segment,
	output logic signed [tlws_pkg::LON_W-1:0] out_lon,
	output logic signed [tlws_pkg::LAT_W-1:0] out_lat,
	output logic signed [tlws_pkg::ALT_W-1:0] out_alt,
	output logic [1:0]                        kind,
	output logic                              last
);
	localparam int W = tlws_pkg::WIDE_W;
	localparam int PW = 2 * W;
	localparam int CW = $clog2(PW + 1);
	// longitude offset to the edge stays below 2^33 in magnitude
	localparam int NM_W = 33;
	localparam logic signed [W-1:0] D90 = W'(90) <<< FRAC_BITS;
	localparam logic signed [W-1:0] D180 = W'(180) <<< FRAC_BITS;
	localparam logic signed [W-1:0] D360 = W'(360) <<< FRAC_BITS;

	typedef enum logic [2:0] {B_IDLE, B_GEO, B_MUL, B_DIV, B_FIN, B_OUT} bstate_t;
	bstate_t st_q;

	tlws_pkg::job_t j_q;
	logic signed [W-1:0] num_q, den_q, dy_q, ex_q;
	logic neg_q, trivial_q;
	logic [PW-1:0] rem_q, quo_q;
	logic [W-1:0] dmag_q;
	logic [CW-1:0] cnt_q;

	logic signed [W-1:0] x1, x2, xe, x2a, xea, xfin, nm, dn, dyv;
	logic anti, east;

	function automatic logic we(input logic signed [W-1:0] a, input logic signed [W-1:0] b);
		we = (a > D90) && (b < -D90);
	endfunction

	always_comb begin
		x1 = W'(j_q.p_lon);
		x2 = W'(j_q.cur_lon);
		anti = we(x1, x2) || we(x2, x1);
		east = (x1 < x2 && !anti) || (x1 > x2 && anti);
		x2a = x2; xea = '0; xfin = '0;
		if (east) begin
			xe = j_q.leaving ? W'(j_q.right) : W'(j_q.left);
			if (x2 < x1) x2a = x2 + D360;
			xea = (xe < x1) ? xe + D360 : xe;
			xfin = (xea > D180) ? xea - D360 : xea;
			xfin = xfin + (j_q.leaving ? -W'(1) : W'(1));
		end else begin
			xe = j_q.leaving ? W'(j_q.left) : W'(j_q.right);
			if (x2 > x1) x2a = x2 - D360;
			xea = (xe > x1) ? xe - D360 : xe;
			xfin = (xea < -D180) ? xea + D360 : xea;
			xfin = xfin + (j_q.leaving ? W'(1) : -W'(1));
		end
		nm = xea - x1;
		dn = x2a - x1;
		dyv = W'(j_q.cur_lat) - W'(j_q.p_lat);
	end

	assign job_take = (st_q == B_IDLE) && job_valid;

	logic [PW-1:0] trial;
	logic [W:0] sub;
	logic signed [W-1:0] q_sat, y;
	logic [W-1:0] nabs, yabs, dabs;
	always_comb begin
		nabs = (num_q < 0) ? -num_q : num_q;
		yabs = (dy_q < 0) ? -dy_q : dy_q;
		dabs = (den_q < 0) ? -den_q : den_q;
		trial = {rem_q[PW-2:0], quo_q[PW-1]};
		sub = {1'b0, trial[W-1:0]} - {1'b0, dmag_q};
		q_sat = (quo_q > PW'(2 * D90)) ? 2 * D90 : W'(quo_q);
		y = neg_q ? W'(j_q.p_lat) - q_sat : W'(j_q.p_lat) + q_sat;
		if (y > D90) y = D90;
		else if (y < -D90) y = -D90;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			out_valid <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (out_valid && !out_stall && st_q != B_OUT) out_valid <= 1'b0;
			case (st_q)
				B_IDLE: if (job_valid) begin
					j_q <= job;
					st_q <= job.is_edge ? B_GEO : B_OUT;
				end
				B_GEO: begin
					num_q <= nm; den_q <= dn; dy_q <= dyv; ex_q <= xfin;
					trivial_q <= (dn == 0) || (nm == 0) || (dyv == 0);
					neg_q <= (nm < 0) != ((dn < 0) != (dyv < 0));
					st_q <= B_MUL;
				end
				B_MUL: begin
					// magnitude product plus half divisor, then restoring division
					dmag_q <= dabs;
					quo_q <= PW'(nabs[NM_W-1:0]) * PW'(yabs[tlws_pkg::LAT_W-1:0])
						+ PW'(dabs >> 1);
					rem_q <= '0;
					cnt_q <= CW'(PW);
					st_q <= trivial_q ? B_OUT : B_DIV;
				end
				B_DIV: begin
					if (!sub[W]) begin
						rem_q <= PW'(sub[W-1:0]);
						quo_q <= {quo_q[PW-2:0], 1'b1};
					end else begin
						rem_q <= trial;
						quo_q <= {quo_q[PW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) st_q <= B_FIN;
				end
				B_FIN: st_q <= B_OUT;
				B_OUT: if (!out_valid || !out_stall) begin
					out_valid <= 1'b1;
					segment <= j_q.seg;
					last <= j_q.last;
					if (j_q.is_edge) begin
						out_lon <= tlws_pkg::LON_W'(ex_q);
						out_lat <= trivial_q ? j_q.p_lat : tlws_pkg::LAT_W'(y);
						out_alt <= j_q.p_alt;
						kind <= j_q.leaving ? tlws_pkg::KIND_EXIT : tlws_pkg::KIND_ENTRY;
					end else begin
						out_lon <= j_q.cur_lon;
						out_lat <= j_q.cur_lat;
						out_alt <= j_q.cur_alt;
						kind <= tlws_pkg::KIND_ORIG;
					end
					st_q <= B_IDLE;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end
endmodule

/* bench/testbench.sv */
// Self-checking bench for the longitude window track splitter core.
// Drives track points and window settings, predicts every result in place.
// Depends on tlws_pkg and track_longitude_window_splitter_core.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint DEG = longint'(1) << tlws_pkg::FRAC_BITS_DEF;
	localparam longint DEG90 = 90 * DEG;
	localparam longint DEG180 = 180 * DEG;
	localparam longint DEG360 = 360 * DEG;
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int STALL_LIMIT = 30000;
	localparam int DRAIN_CYCLES = 250;

	typedef struct packed {
		logic signed [tlws_pkg::LON_W-1:0] lon;
		logic signed [tlws_pkg::LAT_W-1:0] lat;
		logic signed [tlws_pkg::ALT_W-1:0] alt;
		logic                              first;
	} track_point_t;

	typedef struct packed {
		logic                       seg;
		logic [tlws_pkg::LON_W-1:0] lon;
		logic [tlws_pkg::LAT_W-1:0] lat;
		logic [tlws_pkg::ALT_W-1:0] alt;
		logic [1:0]                 kind;
		logic                       last;
	} clip_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [tlws_pkg::LON_W-1:0] point_lon = '0;
	logic signed [tlws_pkg::LAT_W-1:0] point_lat = '0;
	logic signed [tlws_pkg::ALT_W-1:0] point_alt = '0;
	logic first_point = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic segment;
	logic signed [tlws_pkg::LON_W-1:0] out_lon;
	logic signed [tlws_pkg::LAT_W-1:0] out_lat;
	logic signed [tlws_pkg::ALT_W-1:0] out_alt;
	logic [1:0] kind;
	logic last;

	track_longitude_window_splitter_core dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// window and track state of the predictor
	longint win_left = -DEG180, win_right = DEG180;
	bit win_full = 1'b0;
	longint trk_lon = 0, trk_lat = 0;
	logic [31:0] trk_alt = '0;
	bit trk_vis = 1'b1, trk_seg = 1'b0, trk_busy = 1'b0, trk_done = 1'b0;

	track_point_t point_queue[$];
	clip_result_t pending_results[$];
	track_point_t driven;
	int errors = 0;
	bit quiet = 1'b0;
	bit press_go = 1'b0;

	function automatic longint sat_lat(longint y);
		if (y > DEG90) return DEG90;
		if (y < -DEG90) return -DEG90;
		return y;
	endfunction

	function automatic bit in_window(longint lon);
		if (win_full) return 1'b1;
		if (win_left <= win_right) return lon > win_left && lon <= win_right;
		return lon > win_left || lon <= win_right;
	endfunction

	function automatic bit goes_east(longint a, longint b);
		return a > DEG90 && b < -DEG90;
	endfunction

	function automatic bit goes_west(longint a, longint b);
		return a < -DEG90 && b > DEG90;
	endfunction

	function automatic bit crosses_edge(longint lon, longint pl);
		longint l, r;
		bit pr, rl, pw, lw;
		l = win_left;
		r = win_right;
		if (!goes_east(pl, lon) && !goes_west(pl, lon))
			return (pl <= r && lon > r) || (pl >= r && lon < r) ||
				(pl >= l && lon < l) || (pl <= l && lon > l);
		pr = goes_east(pl, r);
		rl = goes_east(r, lon);
		pw = goes_west(pl, l);
		lw = goes_west(l, lon);
		return (pl > r && pr && lon > r) || (pl <= r && lon <= r && rl) ||
			(pl < r && pr && lon < r) || (pl >= r && lon >= r && rl) ||
			(pl < l && pw && lon < l) || (pl >= l && lon >= l && lw) ||
			(pl > l && pw && lon > l) || (pl <= l && lon <= l && lw);
	endfunction

	function automatic longint lerp_lat(longint x1, longint y1, longint x2, longint y2,
			longint x);
		longint num, den, dy;
		longint unsigned n, d, m, q;
		bit neg;
		num = x - x1;
		den = x2 - x1;
		dy = y2 - y1;
		if (den == 0 || num == 0 || dy == 0) return y1;
		neg = (num < 0) != ((den < 0) != (dy < 0));
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		m = dy < 0 ? -dy : dy;
		q = (n * m + d / 2) / d;
		if (q > 2 * DEG90) q = 2 * DEG90;
		return sat_lat(neg ? y1 - longint'(q) : y1 + longint'(q));
	endfunction

	function automatic void edge_pt(longint x2, longint y2, bit leaving,
			output longint ol, output longint oy);
		longint x1, x;
		bit anti;
		x1 = trk_lon;
		anti = goes_east(x1, x2) || goes_west(x1, x2);
		if ((x1 < x2 && !anti) || (x1 > x2 && anti)) begin
			x = leaving ? win_right : win_left;
			if (x2 < x1) x2 += DEG360;
			if (x < x1) x += DEG360;
			oy = lerp_lat(x1, trk_lat, x2, y2, x);
			if (x > DEG180) x -= DEG360;
			x += leaving ? -1 : 1;
		end else begin
			x = leaving ? win_left : win_right;
			if (x2 > x1) x2 -= DEG360;
			if (x > x1) x -= DEG360;
			oy = lerp_lat(x1, trk_lat, x2, y2, x);
			if (x < -DEG180) x += DEG360;
			x += leaving ? 1 : -1;
		end
		ol = x;
	endfunction

	function automatic void add_result(bit seg, longint lon, longint lat,
			logic [31:0] alt, logic [1:0] k);
		clip_result_t r;
		r.seg = seg;
		r.lon = lon[31:0];
		r.lat = lat[30:0];
		r.alt = alt;
		r.kind = k;
		r.last = 1'b0;
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Work out the results of one accepted point and advance the track state.
	function automatic void clip_point(track_point_t p);
		longint lon, lat, el, ey;
		bit on, crossed;
		int base_count;
		lon = longint'(p.lon);
		lat = sat_lat(longint'(p.lat));
		base_count = pending_results.size();
		if (p.first) begin
			trk_lon = lon;
			trk_vis = 1'b1;
			trk_seg = 1'b0;
			trk_busy = 1'b0;
			trk_done = 1'b0;
		end
		if (trk_done) return;
		on = in_window(lon);
		crossed = crosses_edge(lon, trk_lon);
		if ((on && !crossed) || (on && !trk_vis)) begin
			if (!p.first && !trk_busy) begin
				edge_pt(lon, lat, 1'b0, el, ey);
				add_result(trk_seg, el, ey, trk_alt, tlws_pkg::KIND_ENTRY);
			end
			add_result(trk_seg, lon, lat, p.alt, tlws_pkg::KIND_ORIG);
			trk_busy = 1'b1;
		end else if (trk_busy) begin
			if (trk_seg) begin
				// second exit ends the track silently
				trk_done = 1'b1;
				return;
			end
			edge_pt(lon, lat, 1'b1, el, ey);
			add_result(1'b0, el, ey, trk_alt, tlws_pkg::KIND_EXIT);
			trk_seg = 1'b1;
			trk_busy = 1'b0;
			if (on) begin
				edge_pt(lon, lat, 1'b0, el, ey);
				add_result(1'b1, el, ey, trk_alt, tlws_pkg::KIND_ENTRY);
				add_result(1'b1, lon, lat, p.alt, tlws_pkg::KIND_ORIG);
				trk_busy = 1'b1;
			end
		end
		trk_lon = lon;
		trk_lat = lat;
		trk_alt = p.alt;
		trk_vis = on;
		if (pending_results.size() > base_count)
			pending_results[pending_results.size() - 1].last = 1'b1;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	// input side: hold a stalled request, otherwise idle in bursts or advance
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && !in_stall) clip_point(driven);
			if (in_valid && in_stall) begin
			end else if (in_gap != 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (point_queue.size() == 0) begin
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				in_gap <= $urandom_range(0, 16);
				in_valid <= 1'b0;
			end else begin
				driven = point_queue.pop_front();
				in_valid <= 1'b1;
				point_lon <= driven.lon;
				point_lat <= driven.lat;
				point_alt <= driven.alt;
				first_point <= driven.first;
			end
		end
	end

	// long hold-off of the output, counted here
	int press_left = 0;
	bit press_done = 1'b0;
	always @(posedge clk) begin
		if (press_go && !press_done) begin
			press_left <= 900;
			press_done <= 1'b1;
		end else if (press_left != 0) begin
			press_left <= press_left - 1;
		end
	end

	int out_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		clip_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report("unexpected result, lon", out_lon, 0);
				end else begin
					want = pending_results.pop_front();
					if (segment !== want.seg) report("segment", segment, want.seg);
					if (out_lon !== want.lon) report("out_lon", out_lon, want.lon);
					if (out_lat !== want.lat) report("out_lat", out_lat, want.lat);
					if (out_alt !== want.alt) report("out_alt", out_alt, want.alt);
					if (kind !== want.kind) report("kind", kind, want.kind);
					if (last !== want.last) report("last", last, want.last);
				end
			end
			if (press_left != 0) begin
				out_stall <= 1'b1;
			end else if (out_gap != 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_gap <= $urandom_range(0, 16);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic longint pick(longint lo, longint hi);
		return lo + longint'($urandom_range(0, 32'(hi - lo)));
	endfunction

	function automatic void add_point(longint lon, longint lat, logic [31:0] alt, bit first);
		track_point_t p;
		p.lon = lon[31:0];
		p.lat = lat[30:0];
		p.alt = alt;
		p.first = first;
		point_queue.insert(point_queue.size(), p);
	endfunction

	// Mostly well-formed tracks wandering across the window, some noise.
	function automatic void add_tracks(int count);
		int added, len, sel;
		longint lon, lat;
		added = 0;
		while (added < count) begin
			sel = $urandom_range(0, 9);
			if (sel == 8) begin
				add_point(longint'(signed'($urandom)), longint'($urandom), $urandom,
					$urandom_range(0, 1));
				added++;
				continue;
			end
			len = $urandom_range(3, 12);
			if (len > count - added) len = count - added;
			lon = pick(-DEG180, DEG180);
			for (int i = 0; i < len; i++) begin
				if (i != 0 && $urandom_range(0, 9) != 0) begin
					lon += pick(-70 * DEG, 70 * DEG);
					if (lon > DEG180) lon -= DEG360;
					if (lon < -DEG180) lon += DEG360;
				end
				lat = $urandom_range(0, 9) == 0 ? pick(-DEG180, DEG180) : pick(-DEG90, DEG90);
				add_point(lon, lat, $urandom, i == 0 && sel != 9);
			end
			added += len;
		end
	endfunction

	task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tlws_pkg::REG_LEFT: win_left = longint'(signed'(data));
			tlws_pkg::REG_RIGHT: win_right = longint'(signed'(data));
			tlws_pkg::REG_FULL: win_full = data[0];
			default: ;
		endcase
	endtask

	task automatic set_window(longint l, longint r, bit full);
		cfg_write(tlws_pkg::REG_LEFT, l[31:0]);
		cfg_write(tlws_pkg::REG_RIGHT, r[31:0]);
		cfg_write(tlws_pkg::REG_FULL, {31'b0, full});
		cfg_valid <= 1'b0;
	endtask

	// sample between edges so the driver and monitor have settled
	task automatic drain();
		@(negedge clk);
		while (point_queue.size() != 0 || in_valid || pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset window: continuation without a first mark, antimeridian crossings,
		// second exit, ignored points, restart outside the window
		add_point(10 * DEG, 5 * DEG, 100, 1'b0);
		add_point(170 * DEG, 95 * DEG, 200, 1'b0);
		add_point(-170 * DEG, -10 * DEG, 300, 1'b0);
		add_point(-160 * DEG, 32'h3FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		add_point(-160 * DEG, -40 * DEG, 32'h8000_0000, 1'b0);
		add_point(170 * DEG, 0, 1, 1'b0);
		add_point(0, 0, 2, 1'b0);
		add_point(-DEG180, -(longint'(1) << 30), 3, 1'b1);
		add_point(-170 * DEG, 20 * DEG, 4, 1'b0);
		add_point(32'sh7FFF_FFFF, -DEG90, 5, 1'b0);
		add_point(-(longint'(1) << 31), DEG90, 6, 1'b0);
		add_point(DEG180, 0, 32'hFFFF_FFFF, 1'b1);
		add_point(-DEG180 + 1, 1, 0, 1'b0);
		add_tracks(40);
		drain();

		cfg_write(REG_SPARE, $urandom);
		set_window(-30 * DEG, 60 * DEG, 1'b0);
		add_point(0, 0, 7, 1'b1);
		add_point(80 * DEG, 30 * DEG, 8, 1'b0);
		add_point(-50 * DEG, -30 * DEG, 9, 1'b0);
		add_point(-50 * DEG, 30 * DEG, 10, 1'b0);
		add_point(10 * DEG, 30 * DEG, 11, 1'b0);
		add_point(100 * DEG, 30 * DEG, 12, 1'b0);
		press_go = 1'b1;
		add_tracks(80);
		drain();

		set_window(150 * DEG, -150 * DEG, 1'b0);
		add_tracks(80);
		drain();

		set_window(10 * DEG, 20 * DEG, 1'b1);
		add_tracks(50);
		drain();

		set_window(DEG180, -DEG180, 1'b0);
		add_tracks(50);
		drain();

		for (int n = 0; n < 3; n++) begin
			set_window(pick(-DEG180, DEG180), pick(-DEG180, DEG180), 1'b0);
			add_tracks(40);
			drain();
		end

		quiet = 1'b1;
		set_window(-DEG180, DEG180, 1'b0);
		add_tracks(50);
		drain();

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

/* track_longitude_window_splitter_core.f */
+incdir+hw/rtl
hw/rtl/tlws_pkg.sv
hw/rtl/tlws_front.sv
hw/rtl/tlws_queue.sv
hw/rtl/tlws_back.sv
hw/rtl/track_longitude_window_splitter_core.sv
bench/testbench.sv
